@@ hdl/mcpwm_pkg.sv @@
// Package for the multi-channel PWM generator.
// Payload structs, field widths and operation codes; no dependencies.
package mcpwm_pkg;

    localparam int CH_W   = 5;
    localparam int TICK_W = 32;
    localparam int PINS_W = 32;

    // operation codes
    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_SETUP = 1'b1;

    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [TICK_W-1:0] t_tick;

    typedef struct packed {
        logic  operation;
        t_chan channel;
        t_tick timestamp;
        t_tick period_ticks;
        t_tick duty_ticks;
    } t_in_item;

    typedef struct packed {
        t_chan             out_channel;
        logic              level;
        logic              level_changed;
        logic [PINS_W-1:0] pin_levels;
        t_tick             worst_period_error;
        t_tick             worst_duty_error;
    } t_out_item;

endpackage

@@ hdl/mcpwm_ifs.sv @@
// Valid/ready channel interfaces for the PWM generator.
// Depends on mcpwm_pkg for the payload structs.
interface mcpwm_in_if;
    import mcpwm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcpwm_out_if;
    import mcpwm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/multi_channel_pwm_generator.sv @@
// Top level of the multi-channel PWM generator.
// Depends on mcpwm_pkg and the channel interfaces in mcpwm_ifs.sv.
//
// Each transfer on the input channel either sets up one channel (period and duty,
// clearing its level, period start and first-poll flag) or polls one channel with
// the timestamp that the item carries; every item yields exactly one result with
// the channel's level, whether this poll made an edge, all pin levels and the
// worst rising and falling lateness seen so far (first poll of a channel skipped).
// An item passes an input register, combinational logic that reads and updates the
// per-channel registers, and an output register. One item is taken every cycle
// while the output is not stalled, since the channel state is written back in the same
// cycle the result is registered. Per-channel state lives in flip-flops that reset
// clears directly; channels at or above CHANNELS are ignored and report level 0.
module multi_channel_pwm_generator #(
    parameter int CHANNELS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mcpwm_in_if.sink            i_in_ch,
    mcpwm_out_if.source         o_res_ch
);
    import mcpwm_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W:0] CH_LIM = (CH_W+1)'(CHANNELS);

    // input register
    logic     r_in_valid;
    t_in_item r_in;
    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // channel state
    t_tick               r_start  [CHANNELS];
    t_tick               r_period [CHANNELS];
    t_tick               r_duty   [CHANNELS];
    logic [CHANNELS-1:0] r_pin;
    logic [CHANNELS-1:0] r_seen;
    t_tick               r_max_per;
    t_tick               r_max_dut;

    logic                advance;
    logic                in_range;
    logic [IDX_W-1:0]    idx;
    t_tick               per;
    t_tick               dut;
    t_tick               start;
    logic                high;
    logic                seen;
    t_tick               td;
    t_tick               late_p;
    t_tick               late_d;
    logic                past_per;
    logic                rise;
    logic                fall;
    logic                jump;
    logic                is_poll;
    logic [CHANNELS-1:0] n_pin;
    logic [CHANNELS-1:0] ch_mask;
    t_tick               n_max_per;
    t_tick               n_max_dut;
    t_tick               n_start;
    t_out_item           n_out;

    assign advance        = r_in_valid && (!r_out_valid || o_res_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || advance;
    assign o_res_ch.valid = r_out_valid;
    assign o_res_ch.data  = r_out;

    always_comb begin
        in_range = ({1'b0, r_in.channel} < CH_LIM);
        idx      = IDX_W'(r_in.channel);
        is_poll  = (r_in.operation == OP_POLL);
        ch_mask  = '0;
        per      = '0;
        dut      = '0;
        start    = '0;
        high     = 1'b0;
        seen     = 1'b0;
        if (in_range) begin
            ch_mask[idx] = 1'b1;
            per          = r_period[idx];
            dut          = r_duty[idx];
            start        = r_start[idx];
            high         = r_pin[idx];
            seen         = r_seen[idx];
        end
        td       = r_in.timestamp - start;
        late_p   = td - per;
        late_d   = td - dut;
        past_per = (td > per);
        rise     = in_range && is_poll && past_per && !high;
        fall     = in_range && is_poll && !past_per && (td > dut) && high;
        // more than two periods behind: restart the period at the poll time
        jump     = {1'b0, td} > {per, 1'b0};
        n_start  = jump ? r_in.timestamp : start + per;

        n_max_per = r_max_per;
        n_max_dut = r_max_dut;
        if (rise && seen && late_p > r_max_per) begin
            n_max_per = late_p;
        end
        if (fall && seen && late_d > r_max_dut) begin
            n_max_dut = late_d;
        end

        n_pin = r_pin;
        if (in_range && !is_poll) begin
            n_pin = r_pin & ~ch_mask;
        end else if (rise) begin
            n_pin = r_pin | ch_mask;
        end else if (fall) begin
            n_pin = r_pin & ~ch_mask;
        end

        n_out.out_channel        = r_in.channel;
        n_out.level              = |(n_pin & ch_mask);
        n_out.level_changed      = rise || fall;
        n_out.pin_levels         = PINS_W'(n_pin);
        n_out.worst_period_error = n_max_per;
        n_out.worst_duty_error   = n_max_dut;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pin       <= '0;
            r_seen      <= '0;
            r_max_per   <= '0;
            r_max_dut   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_start[c]  <= '0;
                r_period[c] <= '0;
                r_duty[c]   <= '0;
            end
        end else begin
            if (i_in_ch.ready) begin
                r_in_valid <= i_in_ch.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_pin     <= n_pin;
                r_max_per <= n_max_per;
                r_max_dut <= n_max_dut;
                if (in_range) begin
                    if (is_poll) begin
                        r_seen[idx] <= 1'b1;
                        if (rise) begin
                            r_start[idx] <= n_start;
                        end
                    end else begin
                        r_seen[idx]   <= 1'b0;
                        r_start[idx]  <= '0;
                        r_period[idx] <= r_in.period_ticks;
                        r_duty[idx]   <= r_in.duty_ticks;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in <= i_in_ch.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_rise_sets_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && rise |=> r_pin[$past(idx)])
        else $error("rising edge did not set pin");

    a_max_per_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_max_per >= $past(r_max_per))
        else $error("worst period lateness decreased");

    a_max_dut_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_max_dut >= $past(r_max_dut))
        else $error("worst duty lateness decreased");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("stalled item dropped");

    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.level_changed |-> {1'b0, r_out.out_channel} < CH_LIM)
        else $error("edge reported on unused channel");

endmodule

@@ tb/multi_channel_pwm_generator_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for multi_channel_pwm_generator.
// Depends on mcpwm_pkg, mcpwm_ifs.sv and the RTL top level; needs nothing else.
module multi_channel_pwm_generator_test;
    import mcpwm_pkg::*;

    localparam int CHANNELS    = 32;
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int LATENCY     = 2;

    logic i_clk;
    logic i_rst_n;

    mcpwm_in_if  in_ch ();
    mcpwm_out_if res_ch ();

    multi_channel_pwm_generator #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch),
        .o_res_ch(res_ch)
    );

    // predicted channel state
    t_tick       pred_start  [CHANNELS];
    t_tick       pred_period [CHANNELS];
    t_tick       pred_duty   [CHANNELS];
    logic [31:0] pred_levels;
    logic [31:0] pred_seen;
    t_tick       pred_worst_period;
    t_tick       pred_worst_duty;

    t_out_item pending_reports[$];

    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_requests;
    int    hold_served;
    int    errors;
    int    n_setups;
    int    n_polls;
    int    n_edges;
    int    n_checked;
    int    quiet_cycles;
    t_tick tick_now;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_in_item make_item(logic op, t_chan ch, t_tick ts, t_tick per,
                                           t_tick duty);
        t_in_item it;
        it.operation    = op;
        it.channel      = ch;
        it.timestamp    = ts;
        it.period_ticks = per;
        it.duty_ticks   = duty;
        return it;
    endfunction

    // Next pin report for one accepted item; updates the predicted state.
    function automatic t_out_item predict_pin_report(t_in_item it);
        t_out_item   rep;
        logic [31:0] m;
        t_tick       per;
        t_tick       duty;
        t_tick       td;
        logic        seen;
        logic        high;
        logic        changed;
        int          ch;
        ch      = int'(it.channel);
        m       = 32'b1 << ch;
        changed = 1'b0;
        if (ch < CHANNELS) begin
            if (it.operation == OP_SETUP) begin
                pred_period[ch] = it.period_ticks;
                pred_duty[ch]   = it.duty_ticks;
                pred_start[ch]  = '0;
                pred_levels &= ~m;
                pred_seen   &= ~m;
            end else begin
                per  = pred_period[ch];
                duty = pred_duty[ch];
                td   = it.timestamp - pred_start[ch];
                seen = pred_seen[ch];
                high = pred_levels[ch];
                if (td > per) begin
                    if (!high) begin
                        pred_levels |= m;
                        changed = 1'b1;
                        // more than two periods late: restart from now
                        if ({1'b0, td} > {per, 1'b0})
                            pred_start[ch] = it.timestamp;
                        else
                            pred_start[ch] = pred_start[ch] + per;
                        if (seen && (td - per) > pred_worst_period)
                            pred_worst_period = td - per;
                    end
                end else if (td > duty && high) begin
                    pred_levels &= ~m;
                    changed = 1'b1;
                    if (seen && (td - duty) > pred_worst_duty)
                        pred_worst_duty = td - duty;
                end
                pred_seen |= m;
            end
        end
        rep.out_channel        = it.channel;
        rep.level              = (ch < CHANNELS) ? pred_levels[ch] : 1'b0;
        rep.level_changed      = changed;
        rep.pin_levels         = pred_levels;
        rep.worst_period_error = pred_worst_period;
        rep.worst_duty_error   = pred_worst_duty;
        return rep;
    endfunction

    task automatic send_item(input t_in_item it);
        t_out_item rep;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        rep = predict_pin_report(it);
        pending_reports.push_back(rep);
        if (it.operation == OP_SETUP)
            n_setups++;
        else
            n_polls++;
        if (rep.level_changed)
            n_edges++;
    endtask

    task automatic send_poll(input t_chan ch, input t_tick ts);
        send_item(make_item(OP_POLL, ch, ts, $urandom, $urandom));
    endtask

    task automatic send_setup(input t_chan ch, input t_tick per, input t_tick duty);
        send_item(make_item(OP_SETUP, ch, $urandom, per, duty));
    endtask

    task automatic test_setup_extremes();
        send_setup(5'd0, '0, '0);
        send_poll(5'd0, '0);
        send_poll(5'd0, 32'd1);
        send_setup(5'd31, '1, '1);
        send_poll(5'd31, '1);
        send_poll(5'd31, '0);
        // setup on a high pin drops it
        send_setup(5'd0, '0, '1);
    endtask

    task automatic test_edges_and_lateness();
        send_setup(5'd3, 32'd100, 32'd40);
        send_poll(5'd3, 32'd0);
        send_poll(5'd3, 32'd105);
        send_poll(5'd3, 32'd150);
        send_poll(5'd3, 32'd150);
        send_poll(5'd3, 32'd260);
        send_poll(5'd3, 32'd500);
        // first poll of a channel never counts toward lateness
        send_setup(5'd7, 32'd10, 32'd5);
        send_poll(5'd7, 32'd50);
    endtask

    task automatic test_wrap_and_two_period();
        send_setup(5'd12, 32'd100, 32'd50);
        send_poll(5'd12, 32'hFFFF_FFF0);
        send_poll(5'd12, 32'h0000_0010);
        send_poll(5'd12, 32'h0000_0040);
        send_poll(5'd12, 32'h0000_0060);
        send_setup(5'd20, 32'h8000_0000, 32'h4000_0000);
        send_poll(5'd20, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        t_in_item it;
        int       kind;
        t_tick    per;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            if (kind < 78) begin
                tick_now += ($urandom_range(99) < 3) ? $urandom_range(1000, 100000)
                                                      : $urandom_range(0, 40);
                it = make_item(OP_POLL,
                               t_chan'(($urandom_range(9) < 7) ? $urandom_range(7)
                                                               : $urandom_range(31)),
                               tick_now, $urandom, $urandom);
            end else if (kind < 88) begin
                per = $urandom_range(1, 120);
                it  = make_item(OP_SETUP, t_chan'($urandom_range(31)), $urandom, per,
                                $urandom_range(0, per + 10));
            end else if (kind < 91) begin
                it = make_item(OP_SETUP, t_chan'($urandom_range(31)), $urandom,
                               $urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0);
            end else begin
                it.operation    = 1'($urandom_range(1));
                it.channel      = t_chan'($urandom_range(31));
                it.timestamp    = $urandom;
                it.period_ticks = $urandom;
                it.duty_ticks   = $urandom;
            end
            send_item(it);
        end
    endtask

    // Receiver stalls for a long stretch while items keep coming.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        for (int n = 0; n < 30; n++) begin
            tick_now += $urandom_range(0, 30);
            send_poll(t_chan'($urandom_range(7)), tick_now);
        end
    endtask

    // result receiver
    initial begin
        int hold_left;
        hold_left     = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : check_reports
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result transfer for channel %0d", res_ch.data.out_channel);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("out_channel", 32'(want.out_channel),
                            32'(res_ch.data.out_channel));
                check_field("level", 32'(want.level), 32'(res_ch.data.level));
                check_field("level_changed", 32'(want.level_changed),
                            32'(res_ch.data.level_changed));
                check_field("pin_levels", want.pin_levels, res_ch.data.pin_levels);
                check_field("worst_period_error", want.worst_period_error,
                            res_ch.data.worst_period_error);
                check_field("worst_duty_error", want.worst_duty_error,
                            res_ch.data.worst_duty_error);
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            pred_start[c]  = '0;
            pred_period[c] = '0;
            pred_duty[c]   = '0;
        end
        pred_levels       = '0;
        pred_seen         = '0;
        pred_worst_period = '0;
        pred_worst_duty   = '0;
        hold_requests     = 0;
        hold_served       = 0;
        errors            = 0;
        n_setups          = 0;
        n_polls           = 0;
        n_edges           = 0;
        n_checked         = 0;
        quiet_cycles      = 0;
        send_idle_pct     = 30;
        recv_idle_pct     = 49;
        in_ch.valid      <= 1'b0;
        in_ch.data       <= '0;
        i_rst_n          <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_setup_extremes();
        test_edges_and_lateness();
        test_wrap_and_two_period();
        tick_now = 32'hFFFF_F800;
        test_random_traffic(240, 30, 49);
        test_random_traffic(240, 49, 30);
        test_backpressure();
        test_random_traffic(240, 0, 0);
        in_ch.valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Ran %0d setups and %0d polls with %0d pin edges; %0d results checked.",
                 n_setups, n_polls, n_edges, n_checked);
        $display("Traffic covered wrapped timestamps, late edges and a long output stall.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ multi_channel_pwm_generator.f @@
hdl/mcpwm_pkg.sv
hdl/mcpwm_ifs.sv
hdl/multi_channel_pwm_generator.sv
tb/multi_channel_pwm_generator_test.sv
